// ----- sv/trq_pkg.sv -----
// ============================================================================
// trq_pkg
// Shared types and constants of the timestamp range queue: register indexes,
// the stored entry layout and the control/status words between controller
// and datapath.
// ============================================================================
package trq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int WORD_W              = 32;
   localparam int CAP_REG_W           = 7;
   localparam int CSR_IDX_W           = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_CAPACITY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_OFFSET    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_SIZE      = 2'd3;

   localparam logic [CAP_REG_W-1:0] CAPACITY_RESET = 7'd64;

   // Command codes
   localparam logic CMD_LOOKUP = 1'b1;

   // Timestamp returned when nothing matched
   localparam logic [WORD_W-1:0] STAMP_NONE = 32'hFFFF_FFFF;

   // One queued entry
   typedef struct packed {
      logic [WORD_W-1:0] stamp;
      logic [WORD_W-1:0] start;
      logic [WORD_W-1:0] length;
      logic [WORD_W-1:0] extra;
   } trq_entry_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // word accepted this cycle
      logic push;      // run a push, or a no-op when disabled
      logic fold;      // fold lookup position, set up the scan
      logic scan;      // scan one entry per cycle
   } trq_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic lookup;     // incoming word is an enabled lookup
      logic scan_done;  // scan ends this cycle
   } trq_status_type;

   // Controller states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PUSH = 5'b00010,
      ST_FOLD = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_RESP = 5'b10000
   } trq_state_type;

endpackage

// ----- sv/trq_ctrl.sv -----
// ============================================================================
// trq_ctrl
// Sequencer of the timestamp range queue: accepts one word, steers the
// datapath through push or lookup and raises the result strobe.
// ============================================================================
module trq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  trq_pkg::trq_status_type status,
   output trq_pkg::trq_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import trq_pkg::*;

   trq_state_type state_ff;
   trq_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.lookup ? ST_FOLD : ST_PUSH;
            end
         end
         ST_PUSH: state_in = ST_RESP;
         ST_FOLD: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Drive datapath commands and handshake
   assign cmd.capture = (state_ff == ST_IDLE) && start;
   assign cmd.push    = (state_ff == ST_PUSH);
   assign cmd.fold    = (state_ff == ST_FOLD);
   assign cmd.scan    = (state_ff == ST_SCAN);
   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);

endmodule

// ----- sv/trq_datapath.sv -----
// ============================================================================
// trq_datapath
// Configuration registers, entry memory, queue indexes and the lookup scan
// of the timestamp range queue.
// ============================================================================
module trq_datapath #(
   parameter int QUEUE_DEPTH = trq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  trq_pkg::trq_cmd_type                cmd,
   output trq_pkg::trq_status_type             status,
   input  logic                                csr_write_enable,
   input  logic [trq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [trq_pkg::WORD_W-1:0]          csr_write_data,
   input  logic                                req_command,
   input  logic [trq_pkg::WORD_W-1:0]          req_stamp,
   input  logic [trq_pkg::WORD_W-1:0]          req_position,
   input  logic [trq_pkg::WORD_W-1:0]          req_span_length,
   input  logic [trq_pkg::WORD_W-1:0]          req_extra_word,
   output logic                                rsp_found,
   output logic [trq_pkg::WORD_W-1:0]          rsp_out_stamp,
   output logic [trq_pkg::WORD_W-1:0]          rsp_out_position,
   output logic [trq_pkg::WORD_W-1:0]          rsp_out_length,
   output logic [trq_pkg::WORD_W-1:0]          rsp_out_extra,
   output logic                                rsp_queue_full,
   output logic                                rsp_overflow_error
);
   import trq_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CAP_W = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W;

   // Fold an index back below the capacity
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W-1:0] n,
                                                 input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] r;
      r = (n >= c) ? n - c : n;
      if (r >= c) begin
         r = '0;
      end
      return r[IDX_W-1:0];
   endfunction

   // Configuration
   logic                 enable_ff;
   logic [CAP_REG_W-1:0] capacity_ff;
   logic [WORD_W-1:0]    offset_ff;
   logic [WORD_W-1:0]    size_ff;

   // Request word
   logic [WORD_W-1:0]    stamp_ff;
   logic [WORD_W-1:0]    pos_ff;
   logic [WORD_W-1:0]    len_ff;
   logic [WORD_W-1:0]    extra_ff;
   logic [WORD_W-1:0]    end_ff;

   // Queue state
   logic [CNT_W-1:0]     count_ff;
   logic [IDX_W-1:0]     wr_idx_ff;
   logic [IDX_W-1:0]     rd_idx_ff;

   // Scan state
   logic [IDX_W-1:0]     scan_addr_ff;
   logic [CNT_W-1:0]     issue_ff;
   logic [CNT_W-1:0]     chk_ff;
   logic                 vld_ff;
   logic [IDX_W-1:0]     tag_ff;
   trq_entry_type        rd_q_ff;

   // Entry memory
   trq_entry_type        mem [QUEUE_DEPTH];

   // Result
   logic                 res_found_ff;
   logic [WORD_W-1:0]    res_stamp_ff;
   logic [WORD_W-1:0]    res_pos_ff;
   logic [WORD_W-1:0]    res_len_ff;
   logic [WORD_W-1:0]    res_extra_ff;
   logic                 res_full_ff;
   logic                 res_ovf_ff;

   logic [CAP_W-1:0]     cap_wide;
   logic [CNT_W-1:0]     cap;
   logic [IDX_W-1:0]     push_addr;
   logic                 push_ok;
   logic                 push_ovf;
   logic [CNT_W-1:0]     push_count;
   logic [WORD_W-1:0]    span_end;
   logic [WORD_W-1:0]    span_end_wrap;
   logic                 covers;
   logic                 hit;
   logic                 issue_go;
   logic [CNT_W-1:0]     hit_count;
   trq_entry_type        wr_entry;

   // Saturate capacity to 1..depth
   always_comb begin
      cap_wide = CAP_W'(capacity_ff);
      if (cap_wide == '0) begin
         cap_wide = CAP_W'(1);
      end else if (cap_wide > CAP_W'(QUEUE_DEPTH)) begin
         cap_wide = CAP_W'(QUEUE_DEPTH);
      end
      cap = cap_wide[CNT_W-1:0];
   end

   // Push decision
   assign push_addr  = wrap_idx(CNT_W'(wr_idx_ff), cap);
   assign push_ok    = cmd.push && enable_ff && !stamp_ff[WORD_W-1] && (count_ff < cap);
   assign push_ovf   = enable_ff && !stamp_ff[WORD_W-1] && (count_ff >= cap);
   assign push_count = push_ok ? count_ff + CNT_W'(1) : count_ff;
   assign wr_entry   = '{stamp: stamp_ff, start: pos_ff, length: len_ff, extra: extra_ff};

   // Span check of the entry read last cycle
   assign span_end      = rd_q_ff.start + rd_q_ff.length;
   assign span_end_wrap = span_end - size_ff;
   always_comb begin
      if (span_end <= end_ff) begin
         covers = (rd_q_ff.start <= pos_ff) && (pos_ff < span_end);
      end else begin
         covers = ((rd_q_ff.start <= pos_ff) && (pos_ff < end_ff)) ||
                  ((offset_ff <= pos_ff) && (pos_ff < span_end_wrap));
      end
   end

   assign hit       = cmd.scan && vld_ff && covers;
   assign issue_go  = cmd.scan && (issue_ff != count_ff);
   assign hit_count = count_ff - chk_ff;

   assign status.lookup    = enable_ff && (req_command == CMD_LOOKUP);
   assign status.scan_done = cmd.scan && (hit || (chk_ff == count_ff));

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         capacity_ff <= CAPACITY_RESET;
         offset_ff   <= '0;
         size_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_QUEUE_ENABLE:   enable_ff   <= csr_write_data[0];
            CSR_QUEUE_CAPACITY: capacity_ff <= csr_write_data[CAP_REG_W-1:0];
            CSR_RING_OFFSET:    offset_ff   <= csr_write_data;
            CSR_RING_SIZE:      size_ff     <= csr_write_data;
         endcase
      end
   end

   // Capture request word, fold lookup position into the ring
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         stamp_ff <= req_stamp;
         pos_ff   <= req_position;
         len_ff   <= req_span_length;
         extra_ff <= req_extra_word;
         end_ff   <= offset_ff + size_ff;
      end else if (cmd.fold && (pos_ff >= end_ff)) begin
         pos_ff <= pos_ff - size_ff;
      end
   end

   // Entry memory: write on push, registered read during scan
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[push_addr] <= wr_entry;
      end
      if (issue_go) begin
         rd_q_ff <= mem[scan_addr_ff];
         tag_ff  <= scan_addr_ff;
      end
   end

   // Queue indexes and scan counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         scan_addr_ff <= '0;
         issue_ff     <= '0;
         chk_ff       <= '0;
         vld_ff       <= 1'b0;
      end else begin
         if (push_ok) begin
            count_ff  <= push_count;
            wr_idx_ff <= wrap_idx(CNT_W'(push_addr) + CNT_W'(1), cap);
         end
         if (cmd.fold) begin
            scan_addr_ff <= wrap_idx(CNT_W'(rd_idx_ff), cap);
            issue_ff     <= '0;
            chk_ff       <= '0;
            vld_ff       <= 1'b0;
         end else if (cmd.scan) begin
            vld_ff <= issue_go;
            if (issue_go) begin
               scan_addr_ff <= wrap_idx(CNT_W'(scan_addr_ff) + CNT_W'(1), cap);
               issue_ff     <= issue_ff + CNT_W'(1);
            end
            if (vld_ff && !hit) begin
               chk_ff <= chk_ff + CNT_W'(1);
            end
         end
         // Drop the skipped entries, keep the match at the head
         if (hit) begin
            count_ff  <= hit_count;
            rd_idx_ff <= tag_ff;
         end
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         res_found_ff <= 1'b0;
         res_stamp_ff <= STAMP_NONE;
         res_pos_ff   <= '0;
         res_len_ff   <= '0;
         res_extra_ff <= '0;
         res_full_ff  <= enable_ff && (push_count >= cap);
         res_ovf_ff   <= push_ovf;
      end else if (status.scan_done) begin
         res_found_ff <= hit;
         res_ovf_ff   <= 1'b0;
         if (hit) begin
            res_stamp_ff <= rd_q_ff.stamp;
            res_pos_ff   <= rd_q_ff.start;
            res_len_ff   <= rd_q_ff.length;
            res_extra_ff <= rd_q_ff.extra;
            res_full_ff  <= (hit_count >= cap);
         end else begin
            res_stamp_ff <= STAMP_NONE;
            res_pos_ff   <= '0;
            res_len_ff   <= '0;
            res_extra_ff <= '0;
            res_full_ff  <= (count_ff >= cap);
         end
      end
   end

   assign rsp_found          = res_found_ff;
   assign rsp_out_stamp      = res_stamp_ff;
   assign rsp_out_position   = res_pos_ff;
   assign rsp_out_length     = res_len_ff;
   assign rsp_out_extra      = res_extra_ff;
   assign rsp_queue_full     = res_full_ff;
   assign rsp_overflow_error = res_ovf_ff;

endmodule

// ----- sv/timestamp_range_queue.sv -----
// ============================================================================
// timestamp_range_queue
// Circular queue of timestamp entries, each covering a span of a ring data
// buffer. Push appends an entry; lookup finds the first queued entry whose
// span covers a buffer position and drops the entries ahead of it.
// ============================================================================
//
//  channel   handshake                 payload
//  --------  ------------------------  ---------------------------------------
//  request   start / busy              req_command, req_stamp, req_position,
//                                      req_span_length, req_extra_word
//  result    rsp_valid (one cycle)     rsp_found, rsp_out_*, rsp_queue_full,
//                                      rsp_overflow_error
//  config    csr_write_enable          csr_index, csr_write_data
//
//  A push or a disabled access passes through the push and result states
//  before the next word is accepted. A lookup reads the entry memory one
//  entry per cycle through its single registered read port and ends at the
//  first match or after the last queued entry.
//  Reset is synchronous; the entry memory is not cleared, only the indexes,
//  count and configuration registers. The result strobe lasts one cycle and
//  cannot be held off.
//
module timestamp_range_queue #(
   parameter int QUEUE_DEPTH = trq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic signed [trq_pkg::WORD_W-1:0] req_stamp,
   input  logic [trq_pkg::WORD_W-1:0]    req_position,
   input  logic [trq_pkg::WORD_W-1:0]    req_span_length,
   input  logic [trq_pkg::WORD_W-1:0]    req_extra_word,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic signed [trq_pkg::WORD_W-1:0] rsp_out_stamp,
   output logic [trq_pkg::WORD_W-1:0]    rsp_out_position,
   output logic [trq_pkg::WORD_W-1:0]    rsp_out_length,
   output logic [trq_pkg::WORD_W-1:0]    rsp_out_extra,
   output logic                          rsp_queue_full,
   output logic                          rsp_overflow_error,
   input  logic                          csr_write_enable,
   input  logic [trq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [trq_pkg::WORD_W-1:0]    csr_write_data
);
   import trq_pkg::*;

   trq_cmd_type       cmd;
   trq_status_type    status;
   logic [WORD_W-1:0] out_stamp;

   // Sequencer
   trq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Storage and scan
   trq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_command        (req_command),
      .req_stamp          ($unsigned(req_stamp)),
      .req_position       (req_position),
      .req_span_length    (req_span_length),
      .req_extra_word     (req_extra_word),
      .rsp_found          (rsp_found),
      .rsp_out_stamp      (out_stamp),
      .rsp_out_position   (rsp_out_position),
      .rsp_out_length     (rsp_out_length),
      .rsp_out_extra      (rsp_out_extra),
      .rsp_queue_full     (rsp_queue_full),
      .rsp_overflow_error (rsp_overflow_error)
   );

   assign rsp_out_stamp = $signed(out_stamp);

endmodule

// ----- sv/trq_checker.sv -----
// ============================================================================
// trq_checker
// Port-level checks of the timestamp range queue, bound to the top level.
// ============================================================================
module trq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic                              rsp_found,
   input logic signed [trq_pkg::WORD_W-1:0] rsp_out_stamp,
   input logic                              rsp_queue_full,
   input logic                              rsp_overflow_error
);
   import trq_pkg::*;

   // Accepted word keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a word");

   // Result only while a word is in flight
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // One result per word, then back to idle
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   // Miss reports the empty timestamp
   a_miss_stamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> ($unsigned(rsp_out_stamp) == STAMP_NONE))
      else $error("miss without empty timestamp");

   // Overflow only on a full queue and never with a match
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow_error) |-> (rsp_queue_full && !rsp_found))
      else $error("overflow reported on a queue that is not full");

endmodule

bind timestamp_range_queue trq_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_found          (rsp_found),
   .rsp_out_stamp      (rsp_out_stamp),
   .rsp_queue_full     (rsp_queue_full),
   .rsp_overflow_error (rsp_overflow_error)
);

// ----- bench/timestamp_range_queue_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// timestamp_range_queue_tb
// Self-checking bench for the timestamp range queue. A queue of pending words
// feeds a falling-edge driver that works in random bursts; a rising-edge
// monitor predicts every accepted word against its own copy of the queue and
// compares each result word field by field. Register settings change only
// while the block is idle; the capacity changes only once every slot of the
// entry store has been written.
// ============================================================================
module timestamp_range_queue_tb;
   import trq_pkg::*;

   localparam int   DEPTH         = QUEUE_DEPTH_DEFAULT;
   localparam int   SLOT_W        = $clog2(DEPTH);
   localparam int   CYCLE_LIMIT   = 1_000_000;
   localparam int   RANDOM_PHASES = 13;
   localparam int   PHASE_WORDS   = 122;
   localparam int   SETTLE_CYCLES = 80;
   localparam logic CMD_PUSH      = ~CMD_LOOKUP;

   typedef struct packed {
      logic              command;
      logic [WORD_W-1:0] stamp;
      logic [WORD_W-1:0] position;
      logic [WORD_W-1:0] length;
      logic [WORD_W-1:0] extra;
   } access_word_type;

   typedef struct packed {
      logic              found;
      logic [WORD_W-1:0] stamp;
      logic [WORD_W-1:0] position;
      logic [WORD_W-1:0] length;
      logic [WORD_W-1:0] extra;
      logic              full;
      logic              overflow;
   } queue_reply_type;

   typedef struct packed {
      logic [WORD_W-1:0] span_base;
      logic [WORD_W-1:0] span_len;
   } span_type;

   // DUT ports
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic                           req_command = 1'b0;
   logic signed [WORD_W-1:0]       req_stamp = '0;
   logic [WORD_W-1:0]              req_position = '0;
   logic [WORD_W-1:0]              req_span_length = '0;
   logic [WORD_W-1:0]              req_extra_word = '0;
   logic                           rsp_valid;
   logic                           rsp_found;
   logic signed [WORD_W-1:0]       rsp_out_stamp;
   logic [WORD_W-1:0]              rsp_out_position;
   logic [WORD_W-1:0]              rsp_out_length;
   logic [WORD_W-1:0]              rsp_out_extra;
   logic                           rsp_queue_full;
   logic                           rsp_overflow_error;
   logic                           csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]           csr_index = '0;
   logic [WORD_W-1:0]              csr_write_data = '0;

   // Shadow of the queue and its registers
   logic [WORD_W-1:0]    slot_stamp  [DEPTH];
   logic [WORD_W-1:0]    slot_start  [DEPTH];
   logic [WORD_W-1:0]    slot_length [DEPTH];
   logic [WORD_W-1:0]    slot_extra  [DEPTH];
   bit                   slot_written[DEPTH];
   int unsigned          slots_filled = 0;
   int unsigned          held_count = 0;
   int unsigned          wr_ptr = 0;
   int unsigned          rd_ptr = 0;
   logic                 cfg_enable = 1'b0;
   logic [CAP_REG_W-1:0] cfg_capacity = CAPACITY_RESET;
   logic [WORD_W-1:0]    cfg_ring_offset = '0;
   logic [WORD_W-1:0]    cfg_ring_size = '0;

   // Bench bookkeeping
   access_word_type pending_words[$];
   queue_reply_type replies_due[$];
   span_type        recent_spans[$];
   bit              took_word = 1'b0;
   bit              drain_hold = 1'b0;
   int unsigned     burst_left = 1;
   int unsigned     gap_left = 0;
   int unsigned     cycle_count = 0;
   int unsigned     fault_count = 0;

   timestamp_range_queue u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_stamp          (req_stamp),
      .req_position       (req_position),
      .req_span_length    (req_span_length),
      .req_extra_word     (req_extra_word),
      .rsp_valid          (rsp_valid),
      .rsp_found          (rsp_found),
      .rsp_out_stamp      (rsp_out_stamp),
      .rsp_out_position   (rsp_out_position),
      .rsp_out_length     (rsp_out_length),
      .rsp_out_extra      (rsp_out_extra),
      .rsp_queue_full     (rsp_queue_full),
      .rsp_overflow_error (rsp_overflow_error),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // Fold an index back below the capacity; zero if still out of range
   function automatic int unsigned wrap_slot(input int unsigned n, input int unsigned cap);
      int unsigned r;
      r = (n >= cap) ? n - cap : n;
      if (r >= cap) begin
         r = 0;
      end
      return r;
   endfunction

   // Apply one accepted word to the shadow queue and build its result word
   function automatic void apply_access(input access_word_type w,
                                        output queue_reply_type r);
      int unsigned       cap;
      int unsigned       idx;
      int unsigned       i;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] ring_end;
      logic [WORD_W-1:0] look_pos;
      logic [WORD_W-1:0] span_end;
      bit                hit;
      r = '0;
      r.stamp = STAMP_NONE;
      cap = 32'(cfg_capacity);
      if (cap == 0) begin
         cap = 1;
      end else if (cap > DEPTH) begin
         cap = DEPTH;
      end
      if (cfg_enable) begin
         if (w.command == CMD_PUSH) begin
            if (!w.stamp[WORD_W-1]) begin
               if (held_count >= cap) begin
                  r.overflow = 1'b1;
               end else begin
                  idx  = wrap_slot(wr_ptr, cap);
                  slot = SLOT_W'(idx);
                  slot_stamp[slot]  = w.stamp;
                  slot_start[slot]  = w.position;
                  slot_length[slot] = w.length;
                  slot_extra[slot]  = w.extra;
                  if (!slot_written[slot]) begin
                     slots_filled++;
                  end
                  slot_written[slot] = 1'b1;
                  wr_ptr = wrap_slot(idx + 1, cap);
                  held_count++;
               end
            end
         end else begin
            // fold the position into the ring, then scan from the read index
            ring_end = cfg_ring_offset + cfg_ring_size;
            look_pos = w.position;
            if (look_pos >= ring_end) begin
               look_pos = look_pos - cfg_ring_size;
            end
            idx = wrap_slot(rd_ptr, cap);
            for (i = 0; i < held_count; i++) begin
               slot     = SLOT_W'(idx);
               span_end = slot_start[slot] + slot_length[slot];
               if (span_end <= ring_end) begin
                  hit = slot_start[slot] <= look_pos && look_pos < span_end;
               end else begin
                  hit = (slot_start[slot] <= look_pos && look_pos < ring_end) ||
                        (cfg_ring_offset <= look_pos &&
                         look_pos < span_end - cfg_ring_size);
               end
               if (hit) begin
                  // drop the entries ahead of the match, keep the match queued
                  held_count = held_count - i;
                  rd_ptr     = idx;
                  r.found    = 1'b1;
                  r.stamp    = slot_stamp[slot];
                  r.position = slot_start[slot];
                  r.length   = slot_length[slot];
                  r.extra    = slot_extra[slot];
                  break;
               end
               idx = wrap_slot(idx + 1, cap);
            end
         end
         r.full = held_count >= cap;
      end
   endfunction

   function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fault_count++;
      end
   endfunction

   function automatic access_word_type word_of(input logic cmd,
                                               input logic [WORD_W-1:0] stamp,
                                               input logic [WORD_W-1:0] pos,
                                               input logic [WORD_W-1:0] len,
                                               input logic [WORD_W-1:0] extra);
      access_word_type w;
      w.command  = cmd;
      w.stamp    = stamp;
      w.position = pos;
      w.length   = len;
      w.extra    = extra;
      return w;
   endfunction

   // Random push word; spans mostly sit in the ring, some straddle its end
   function automatic access_word_type make_push(input bit allow_negative);
      access_word_type w;
      span_type        sp;
      w.command = CMD_PUSH;
      w.extra   = $urandom;
      case ($urandom_range(0, 9))
         0:       w.stamp = allow_negative ? (32'h8000_0000 | $urandom) : 32'h0;
         1:       w.stamp = 32'h7FFF_FFFF;
         default: w.stamp = $urandom & 32'h7FFF_FFFF;
      endcase
      case ($urandom_range(0, 9))
         0:       w.length = '0;
         1:       w.length = $urandom;
         2:       w.length = 32'hFFFF_FFFF;
         default: w.length = $urandom_range(1, 512);
      endcase
      if (cfg_ring_size == 0 || $urandom_range(0, 7) == 0) begin
         w.position = $urandom;
      end else if ($urandom_range(0, 3) == 0) begin
         w.position = cfg_ring_offset + cfg_ring_size - $urandom_range(1, 64);
      end else begin
         w.position = cfg_ring_offset + ($urandom % cfg_ring_size);
      end
      if (!w.stamp[WORD_W-1]) begin
         sp.span_base = w.position;
         sp.span_len  = w.length;
         recent_spans.push_back(sp);
         if (recent_spans.size() > 32) begin
            void'(recent_spans.pop_front());
         end
      end
      return w;
   endfunction

   // Random lookup word; mostly aimed inside a recently pushed span
   function automatic access_word_type make_lookup();
      access_word_type w;
      span_type        sp;
      w.command = CMD_LOOKUP;
      w.stamp   = $urandom;
      w.length  = $urandom;
      w.extra   = $urandom;
      if (recent_spans.size() != 0 && $urandom_range(0, 3) != 0) begin
         sp = recent_spans[$urandom_range(0, recent_spans.size() - 1)];
         w.position = sp.span_base + ((sp.span_len == 0) ? 0 : ($urandom % sp.span_len));
         if ($urandom_range(0, 3) == 0) begin
            w.position = w.position + cfg_ring_size;
         end
      end else begin
         case ($urandom_range(0, 3))
            0:       w.position = '0;
            1:       w.position = 32'hFFFF_FFFF;
            2:       w.position = cfg_ring_offset + cfg_ring_size - 1;
            default: w.position = $urandom;
         endcase
      end
      return w;
   endfunction

   // Register write: one per cycle, shadow updated at the write edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_QUEUE_ENABLE:   cfg_enable = data[0];
         CSR_QUEUE_CAPACITY: cfg_capacity = data[CAP_REG_W-1:0];
         CSR_RING_OFFSET:    cfg_ring_offset = data;
         CSR_RING_SIZE:      cfg_ring_size = data;
         default:            ;
      endcase
   endtask

   task automatic configure(input logic en, input logic [CAP_REG_W-1:0] cap,
                            input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] span);
      write_reg(CSR_QUEUE_ENABLE, {{(WORD_W-1){1'b0}}, en});
      write_reg(CSR_QUEUE_CAPACITY, {{(WORD_W-CAP_REG_W){1'b0}}, cap});
      write_reg(CSR_RING_OFFSET, base);
      write_reg(CSR_RING_SIZE, span);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Hold until every queued word is accepted and answered and the block is idle
   task automatic drain();
      while (pending_words.size() != 0 || start || replies_due.size() != 0 || busy) begin
         @(posedge clock);
      end
   endtask

   // Driver: launch words in bursts, hold each word until it is accepted
   always @(negedge clock) begin
      access_word_type nxt;
      logic            launch;
      launch = 1'b0;
      nxt    = '0;
      if (!reset && !(start && !took_word)) begin
         if (drain_hold && replies_due.size() == 0) begin
            drain_hold = 1'b0;
         end
         if (drain_hold) begin
            launch = 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
         end else if (pending_words.size() != 0) begin
            nxt    = pending_words.pop_front();
            launch = 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               drain_hold = ($urandom_range(0, 15) == 0);
            end
         end
         start <= launch;
         if (launch) begin
            req_command     <= nxt.command;
            req_stamp       <= nxt.stamp;
            req_position    <= nxt.position;
            req_span_length <= nxt.length;
            req_extra_word  <= nxt.extra;
         end
      end else if (reset) begin
         start <= 1'b0;
      end
   end

   // Monitor: check result words, predict accepted words
   always @(posedge clock) begin
      queue_reply_type due;
      cycle_count++;
      if (!reset && rsp_valid) begin
         if (replies_due.size() == 0) begin
            $error("result word with nothing outstanding");
            fault_count++;
         end else begin
            due = replies_due.pop_front();
            check_field("found", WORD_W'(due.found), WORD_W'(rsp_found));
            check_field("out_stamp", due.stamp, rsp_out_stamp);
            check_field("out_position", due.position, rsp_out_position);
            check_field("out_length", due.length, rsp_out_length);
            check_field("out_extra", due.extra, rsp_out_extra);
            check_field("queue_full", WORD_W'(due.full), WORD_W'(rsp_queue_full));
            check_field("overflow_error", WORD_W'(due.overflow),
                        WORD_W'(rsp_overflow_error));
         end
      end
      took_word = !reset && start && !busy;
      if (took_word) begin
         apply_access(word_of(req_command, req_stamp, req_position, req_span_length,
                              req_extra_word), due);
         replies_due.push_back(due);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("FAILURE");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      int unsigned          phase;
      int unsigned          n;
      logic [CAP_REG_W-1:0] cap;
      logic [WORD_W-1:0]    base;
      logic [WORD_W-1:0]    span;
      span_type             newest;
      foreach (slot_written[k]) begin
         slot_written[k] = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled after reset: both commands do nothing
      pending_words.push_back(word_of(CMD_PUSH, 32'd5, 32'h1000, 32'h10, 32'h1));
      pending_words.push_back(word_of(CMD_LOOKUP, 32'd0, 32'h1000, 32'h0, 32'h0));
      drain();

      // ring 0x1000..0x1FFF
      configure(1'b1, CAPACITY_RESET, 32'h1000, 32'h1000);
      pending_words.push_back(word_of(CMD_LOOKUP, 32'd0, 32'h1000, 32'h0, 32'h0));
      pending_words.push_back(word_of(CMD_PUSH, 32'h0, 32'h1000, 32'h10, 32'h0));
      pending_words.push_back(word_of(CMD_PUSH, 32'h7FFF_FFFF, 32'h1F00, 32'h200,
                                      32'hFFFF_FFFF));
      pending_words.push_back(word_of(CMD_PUSH, 32'h8000_0000, 32'h1500, 32'h10, 32'h0));
      pending_words.push_back(word_of(CMD_PUSH, 32'hFFFF_FFFF, 32'h1600, 32'h10, 32'h0));
      pending_words.push_back(word_of(CMD_PUSH, 32'd100, 32'hFFFF_FFFF, 32'h2,
                                      32'hA5A5_A5A5));
      pending_words.push_back(word_of(CMD_PUSH, 32'd200, 32'h1800, 32'h0, 32'h5A5A_5A5A));
      // hit first entry, hit wrapped part after folding, hit again, then misses
      pending_words.push_back(word_of(CMD_LOOKUP, 32'd0, 32'h1005, 32'h0, 32'h0));
      pending_words.push_back(word_of(CMD_LOOKUP, 32'd0, 32'h2050, 32'h0, 32'h0));
      pending_words.push_back(word_of(CMD_LOOKUP, 32'd0, 32'h1F80, 32'h0, 32'h0));
      pending_words.push_back(word_of(CMD_LOOKUP, 32'd0, 32'h0, 32'h0, 32'h0));
      pending_words.push_back(word_of(CMD_LOOKUP, 32'd0, 32'hFFFF_FFFF, 32'h0, 32'h0));
      drain();

      // fill every slot at full capacity before the capacity may change
      while (slots_filled < DEPTH || held_count < DEPTH) begin
         repeat (8) pending_words.push_back(make_push(1'b1));
         drain();
      end
      // push into the full queue, then look up the base of the most recently pushed span
      newest = recent_spans[$];
      pending_words.push_back(make_push(1'b0));
      pending_words.push_back(word_of(CMD_LOOKUP, $urandom, newest.span_base,
                                      $urandom, $urandom));
      drain();

      // random phases over several settings, extremes among them
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       cap = 7'd1;
            1:       cap = 7'd2;
            2:       cap = 7'd0;
            3:       cap = 7'd127;
            4:       cap = 7'd64;
            5:       cap = 7'd65;
            default: cap = CAP_REG_W'($urandom_range(1, 64));
         endcase
         case (phase % 4)
            0:       base = '0;
            1:       base = 32'hFFFF_FFFF;
            2:       base = 32'hFF00_0421;
            default: base = $urandom;
         endcase
         case (phase % 3)
            0:       span = (phase == 6) ? 32'hFFFF_FFFF : 32'h0;
            1:       span = $urandom_range(1, 32'h10000);
            default: span = $urandom;
         endcase
         configure(phase != 7, cap, base, span);
         for (n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 19) < 11) begin
               pending_words.push_back(make_push(1'b1));
            end else begin
               pending_words.push_back(make_lookup());
            end
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
